@@ rtl/frpc_pkg.sv @@
// Shared constants, command and status types for the fraction reduce block.
`default_nettype none
package frpc_pkg;
	// Table geometry and field widths
	localparam int VALUE_LIMIT = 65536;
	localparam int COUNT_BITS  = 20;
	localparam int VAL_W       = 16;
	localparam int IDX_W       = $clog2(VALUE_LIMIT);
	localparam int I_W         = (IDX_W + 1) / 2;
	localparam int I_MAX       = (1 << I_W) - 1;
	localparam int ROW_W       = 2 * COUNT_BITS;
	localparam int SF_W        = 2 * IDX_W;

	// Request kinds
	localparam logic [1:0] REQ_ACC = 2'd0;
	localparam logic [1:0] REQ_RED = 2'd1;
	localparam logic [1:0] REQ_CLR = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic clr_start;
		logic clr_wr;
		logic clr_sf;
		logic sv_load;
		logic sv_wr;
		logic sv_next_i;
		logic sf_rd;
		logic cnt_rd;
		logic upd;
		logic emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic       clr_last;
		logic       j_in;
		logic       i_last;
		logic [1:0] kind;
		logic       short_val;
		logic       q_one;
		logic       out_free;
	} sts_t;
endpackage
`default_nettype wire

@@ rtl/frpc_ctrl.sv @@
// Controller state machine: table init, sieve, factor loop and clear pass.
`default_nettype none
module frpc_ctrl import frpc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_SV_I   = 4'd1;
	localparam logic [3:0] S_SV_J   = 4'd2;
	localparam logic [3:0] S_IDLE   = 4'd3;
	localparam logic [3:0] S_DISP   = 4'd4;
	localparam logic [3:0] S_RD_SF  = 4'd5;
	localparam logic [3:0] S_RD_CNT = 4'd6;
	localparam logic [3:0] S_UPD    = 4'd7;
	localparam logic [3:0] S_EMIT   = 4'd8;
	localparam logic [3:0] S_CLR    = 4'd9;

	logic [3:0] state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_wr = 1'b1;
				cmd.clr_sf = 1'b1;
				if (sts.clr_last) state_d = S_SV_I;
			end
			S_SV_I: begin
				cmd.sv_load = 1'b1;
				state_d     = S_SV_J;
			end
			S_SV_J: begin
				if (sts.j_in) begin
					cmd.sv_wr = 1'b1;
				end else if (sts.i_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.sv_next_i = 1'b1;
					state_d       = S_SV_I;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.kind) inside
					REQ_CLR: begin
						cmd.clr_start = 1'b1;
						state_d       = S_CLR;
					end
					REQ_ACC, REQ_RED: begin
						if (!sts.short_val) state_d = S_RD_SF;
						else if (sts.kind == REQ_RED) state_d = S_EMIT;
						else state_d = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_RD_SF: begin
				cmd.sf_rd = 1'b1;
				state_d   = S_RD_CNT;
			end
			S_RD_CNT: begin
				cmd.cnt_rd = 1'b1;
				state_d    = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				if (!sts.q_one) state_d = S_RD_SF;
				else if (sts.kind == REQ_RED) state_d = S_EMIT;
				else state_d = S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/frpc_dp.sv @@
// Datapath: factor table, count table, item registers and result register.
`default_nettype none
module frpc_dp import frpc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	input  wire logic [1:0]       in_kind,
	input  wire logic             in_side,
	input  wire logic [VAL_W-1:0] in_value,
	input  wire logic             in_last,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [VAL_W-1:0]      out_value,
	output logic                  out_side,
	output logic                  out_last
);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// Factor table entry: {cofactor, smallest prime}; zero marks a prime
	logic [SF_W-1:0]  sf_mem [VALUE_LIMIT];
	logic [ROW_W-1:0] cnt_mem [VALUE_LIMIT];
	logic [SF_W-1:0]  sf_rd_q;
	logic [ROW_W-1:0] cnt_rd_q;

	logic [IDX_W:0]   clr_q;
	logic [I_W-1:0]   i_q;
	logic [IDX_W:0]   j_q;
	logic [IDX_W-1:0] qj_q;

	logic [1:0]       kind_q;
	logic             side_q, last_q;
	logic [VAL_W-1:0] k_q, res_q;
	logic [IDX_W-1:0] p_q, q_q;

	logic [IDX_W-1:0]      sf_p, sf_q, p_c, q_c;
	logic [IDX_W-1:0]      sf_wa;
	logic [SF_W-1:0]       sf_wd;
	logic                  sf_we;
	logic [IDX_W-1:0]      cnt_wa;
	logic [ROW_W-1:0]      cnt_wd, row_n;
	logic                  cnt_we;
	logic                  sel_hi;
	logic [COUNT_BITS-1:0] c_cur, c_new;
	logic [2*VAL_W-1:0]    prod;
	logic                  val_big;

	// Clear and sieve counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			i_q   <= I_W'(I_MAX);
			j_q   <= '0;
			qj_q  <= '0;
		end else begin
			if (cmd.clr_start) clr_q <= '0;
			else if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.sv_load) begin
				j_q  <= (IDX_W+1)'(i_q) * (IDX_W+1)'(i_q);
				qj_q <= IDX_W'(i_q);
			end else if (cmd.sv_wr) begin
				j_q  <= j_q + (IDX_W+1)'(i_q);
				qj_q <= qj_q + 1'b1;
			end
			if (cmd.sv_next_i) i_q <= i_q - 1'b1;
		end
	end

	// Factor table write port
	always_comb begin
		sf_we = (cmd.clr_wr && cmd.clr_sf) || cmd.sv_wr;
		sf_wa = cmd.sv_wr ? j_q[IDX_W-1:0] : clr_q[IDX_W-1:0];
		sf_wd = cmd.sv_wr ? {qj_q, IDX_W'(i_q)} : '0;
	end

	always_ff @(posedge clk) begin
		if (sf_we) sf_mem[sf_wa] <= sf_wd;
		if (cmd.sf_rd) sf_rd_q <= sf_mem[IDX_W'(k_q)];
	end

	// Prime and cofactor from the table read
	always_comb begin
		sf_p = sf_rd_q[IDX_W-1:0];
		sf_q = sf_rd_q[SF_W-1:IDX_W];
		p_c  = (sf_p == '0) ? IDX_W'(k_q) : sf_p;
		q_c  = (sf_p == '0) ? IDX_W'(1) : sf_q;
	end

	// Count update for the current prime
	always_comb begin
		sel_hi = (kind_q == REQ_ACC) ? side_q : ~side_q;
		c_cur  = sel_hi ? cnt_rd_q[ROW_W-1:COUNT_BITS] : cnt_rd_q[COUNT_BITS-1:0];
		if (kind_q == REQ_ACC) c_new = (c_cur == CNT_MAX) ? c_cur : c_cur + 1'b1;
		else c_new = (c_cur != '0) ? c_cur - 1'b1 : c_cur;
		row_n  = sel_hi ? {c_new, cnt_rd_q[COUNT_BITS-1:0]}
		                : {cnt_rd_q[ROW_W-1:COUNT_BITS], c_new};
		prod   = res_q * VAL_W'(p_q);
		cnt_we = cmd.clr_wr || cmd.upd;
		cnt_wa = cmd.upd ? p_q : clr_q[IDX_W-1:0];
		cnt_wd = cmd.upd ? row_n : '0;
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (cmd.cnt_rd) cnt_rd_q <= cnt_mem[p_c];
	end

	assign val_big = (32'(in_value) >= VALUE_LIMIT);

	// Item registers and running result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			side_q <= in_side;
			last_q <= in_last;
			k_q    <= in_value;
			res_q  <= val_big ? in_value : VAL_W'(1);
		end
		if (cmd.cnt_rd) begin
			p_q <= p_c;
			q_q <= q_c;
		end
		if (cmd.upd) begin
			k_q <= VAL_W'(q_q);
			if (kind_q == REQ_RED && c_cur == '0) res_q <= prod[VAL_W-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value <= res_q;
			out_side  <= side_q;
			out_last  <= last_q;
		end
	end

	// Status back to the controller
	always_comb begin
		sts.clr_last  = (clr_q == (IDX_W+1)'(VALUE_LIMIT - 1));
		sts.j_in      = (32'(j_q) < VALUE_LIMIT);
		sts.i_last    = (i_q == I_W'(2));
		sts.kind      = kind_q;
		sts.short_val = (32'(k_q) >= VALUE_LIMIT) || (k_q <= VAL_W'(1));
		sts.q_one     = (q_q == IDX_W'(1));
		sts.out_free  = !out_valid;
	end
endmodule
`default_nettype wire

@@ rtl/fraction_reduce_prime_cancel.sv @@
// Top level of the fraction reduce block: stream ports, controller and datapath.
//
// Channel   Direction  Contents
// s_*       in         tdata value; tuser {side, req_type}; tlast last_of_list
// m_*       out        tdata reduced_value; tuser side_res; tlast last_of_list_res
//
// After reset a clear pass and a sieve run before the first item is taken.
// An accumulate or reduce item steps through a table read, a count read and
// a count write for each prime factor, and a reduce item then loads the
// result register. A clear item sweeps the count table. Input is stalled
// while an item is in work; a waiting result does not block the next item
// until that item finishes.
`default_nettype none
module fraction_reduce_prime_cancel import frpc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] value
	input  wire logic [2:0]  s_tuser,   // [1:0] req_type, [2] side
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] reduced_value
	output logic [0:0]       m_tuser,   // [0] side_res
	output logic             m_tlast
);
	cmd_t cmd;
	sts_t sts;

	frpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	frpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_kind   (s_tuser[1:0]),
		.in_side   (s_tuser[2]),
		.in_value  (s_tdata),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (m_tdata),
		.out_side  (m_tuser[0]),
		.out_last  (m_tlast)
	);
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the fraction reduce block: queued stimulus, prime-count predictor, stream checks.
`default_nettype none
module tb;
	import frpc_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam int MAX_REPORT = 10;

	typedef struct packed {
		logic [1:0]  kind;
		logic        side;
		logic [15:0] value;
		logic        last;
	} req_t;

	typedef struct packed {
		logic [15:0] value;
		logic        side;
		logic        last;
	} frac_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] value
	logic [2:0]  s_tuser = '0;   // [1:0] req_type, [2] side
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [15:0] reduced_value
	logic [0:0]  m_tuser;        // [0] side_res
	logic        m_tlast;

	fraction_reduce_prime_cancel u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always #2 clk = ~clk;

	// predictor state
	int unsigned           least_prime[VALUE_LIMIT];
	logic [COUNT_BITS-1:0] prime_cnt[2][VALUE_LIMIT];
	req_t                  pending_reqs[$];
	frac_t                 expected_fracs[$];
	int                    n_accepted = 0;
	int                    n_errors = 0;
	int                    hold_cycles = 0;
	bit                    holding = 1'b0;
	bit                    hold_done = 1'b0;
	bit                    took = 1'b0;

	function automatic void fill_sieve();
		int unsigned i, j;
		for (i = 0; i < VALUE_LIMIT; i++)
			least_prime[i] = 0;
		for (i = 2; i < VALUE_LIMIT; i++) begin
			if (least_prime[i] != 0)
				continue;
			least_prime[i] = i;
			for (j = i * i; j < VALUE_LIMIT; j += i)
				if (least_prime[j] == 0)
					least_prime[j] = i;
		end
	endfunction

	function automatic void clear_counts();
		for (int i = 0; i < VALUE_LIMIT; i++) begin
			prime_cnt[0][i] = '0;
			prime_cnt[1][i] = '0;
		end
	endfunction

	// Apply one accepted item to the counts, queue the reduced value if any
	function automatic void cancel_primes(req_t r);
		int unsigned k, p;
		logic [31:0] prod;
		logic        other;
		frac_t       f;
		other = ~r.side;
		k = r.value;
		prod = 32'd1;
		case (r.kind)
			REQ_CLR: begin
				clear_counts();
			end
			REQ_ACC: begin
				while (k > 1) begin
					p = least_prime[k];
					if (prime_cnt[r.side][p] != CNT_MAX)
						prime_cnt[r.side][p]++;
					k = k / p;
				end
			end
			REQ_RED: begin
				while (k > 1) begin
					p = least_prime[k];
					if (prime_cnt[other][p] != '0)
						prime_cnt[other][p]--;
					else
						prod = prod * p;
					k = k / p;
				end
				f = '{prod[15:0], r.side, r.last};
				expected_fracs.insert(expected_fracs.size(), f);
			end
			default: ;
		endcase
	endfunction

	function automatic void add_req(logic [1:0] kind, logic side, logic [15:0] value,
			logic last);
		req_t r;
		r = '{kind, side, value, last};
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 64));
			1: return 16'($urandom_range(1, 1000));
			2: return 16'(1 << $urandom_range(0, 15));
			3: return 16'($urandom_range(60000, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	// Idle windows: no idling while 200 to 299 items have been taken
	function automatic bit sender_idle();
		if (n_accepted >= 200 && n_accepted < 300)
			return 1'b0;
		return $urandom_range(0, 99) < 20;
	endfunction

	// Sample both handshakes and check results
	always @(posedge clk) begin
		frac_t want;
		took = s_tvalid && s_tready;
		if (took) begin
			cancel_primes('{s_tuser[1:0], s_tuser[2], s_tdata, s_tlast});
			n_accepted++;
		end
		if (m_tvalid && m_tready) begin
			if (expected_fracs.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORT)
					$display("unexpected result value=%0d side=%0d last=%0d",
						m_tdata, m_tuser[0], m_tlast);
			end else begin
				want = expected_fracs.pop_front();
				if (want.value !== m_tdata || want.side !== m_tuser[0]
						|| want.last !== m_tlast) begin
					n_errors++;
					if (n_errors <= MAX_REPORT)
						$display("mismatch exp value=%0d side=%0d last=%0d got %0d/%0d/%0d",
							want.value, want.side, want.last,
							m_tdata, m_tuser[0], m_tlast);
				end
			end
		end
	end

	// Drive the next queued item
	always @(negedge clk) begin
		req_t nxt;
		if (arst_n && (!s_tvalid || took)) begin
			if (pending_reqs.size() > 0 && !sender_idle()) begin
				nxt = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= {nxt.side, nxt.kind};
				s_tdata  <= nxt.value;
				s_tlast  <= nxt.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Hold off the receiver for a long stretch once, partway into the run
	always @(negedge clk) begin
		if (!hold_done && n_accepted >= 100) begin
			if (hold_cycles >= 600) begin
				holding <= 1'b0;
				hold_done <= 1'b1;
			end else begin
				holding <= 1'b1;
				hold_cycles <= hold_cycles + 1;
			end
		end
	end

	// Receiver backpressure
	always @(negedge clk) begin
		if (!arst_n || holding)
			m_tready <= 1'b0;
		else if (n_accepted >= 200 && n_accepted < 300)
			m_tready <= 1'b1;
		else
			m_tready <= $urandom_range(0, 99) >= 20;
	end

	initial begin
		int n_num, n_den;
		logic [15:0] nums[$];
		logic [15:0] dens[$];
		fill_sieve();
		clear_counts();

		// directed: extremes, every kind, small and uncovered values
		add_req(REQ_ACC, 1'b0, 16'd12, 1'b0);
		add_req(REQ_ACC, 1'b0, 16'd65535, 1'b1);
		add_req(REQ_ACC, 1'b1, 16'd18, 1'b0);
		add_req(REQ_ACC, 1'b1, 16'd32768, 1'b0);
		add_req(REQ_ACC, 1'b1, 16'd1, 1'b0);
		add_req(REQ_ACC, 1'b1, 16'd0, 1'b1);
		add_req(REQ_RED, 1'b0, 16'd12, 1'b0);
		add_req(REQ_RED, 1'b0, 16'd65535, 1'b1);
		add_req(REQ_RED, 1'b1, 16'd18, 1'b0);
		add_req(REQ_RED, 1'b1, 16'd32768, 1'b0);
		add_req(REQ_RED, 1'b1, 16'd0, 1'b0);
		add_req(REQ_RED, 1'b1, 16'd1, 1'b1);
		add_req(REQ_RED, 1'b0, 16'd65521, 1'b1);
		add_req(2'd3, 1'b1, 16'hffff, 1'b1);
		add_req(2'd3, 1'b0, 16'h0000, 1'b0);
		add_req(REQ_CLR, 1'b0, 16'd5, 1'b0);
		add_req(REQ_RED, 1'b1, 16'd12, 1'b1);
		add_req(REQ_ACC, 1'b0, 16'd2, 1'b0);
		add_req(REQ_RED, 1'b1, 16'd65534, 1'b1);
		add_req(REQ_RED, 1'b0, 16'd43690, 1'b0);
		add_req(REQ_RED, 1'b1, 16'h5555, 1'b1);

		// random: mostly whole fractions (accumulate both lists, then reduce both)
		while (pending_reqs.size() < 545) begin
			case ($urandom_range(0, 19))
				0: add_req(2'd3, 1'($urandom), rand_value(), 1'($urandom));
				1, 2: add_req(2'($urandom_range(0, 1)), 1'($urandom), rand_value(),
					1'($urandom));
				3: if ($urandom_range(0, 9) == 0)
					add_req(REQ_CLR, 1'($urandom), rand_value(), 1'($urandom));
				default: begin
					nums.delete();
					dens.delete();
					n_num = $urandom_range(1, 4);
					n_den = $urandom_range(1, 4);
					for (int i = 0; i < n_num; i++) nums.insert(nums.size(), rand_value());
					for (int i = 0; i < n_den; i++) dens.insert(dens.size(), rand_value());
					for (int i = 0; i < n_num; i++)
						add_req(REQ_ACC, 1'b0, nums[i], i == n_num - 1);
					for (int i = 0; i < n_den; i++)
						add_req(REQ_ACC, 1'b1, dens[i], i == n_den - 1);
					for (int i = 0; i < n_num; i++)
						add_req(REQ_RED, 1'b0, nums[i], i == n_num - 1);
					for (int i = 0; i < n_den; i++)
						add_req(REQ_RED, 1'b1, dens[i], i == n_den - 1);
				end
			endcase
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain stimulus, then results, then let the block settle
		while (pending_reqs.size() > 0 || s_tvalid || expected_fracs.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Startup sieve plus a few table sweeps for clears, taken several times over
	initial begin
		#(4 * 4000000);
		$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
